>>> rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: quadratic root solver shared types and constants
// Field formats, internal word widths and the stage records that travel
// along the square-root and divider cell chains.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int COUNT_BITS  = 2;

   // c - level and its magnitude need one more bit than a word
   localparam int CMAG_BITS   = WORD_BITS + 1;
   localparam int BSQ_BITS    = 2 * WORD_BITS;
   localparam int PROD_BITS   = WORD_BITS + CMAG_BITS;
   localparam int WIDE_BITS   = PROD_BITS + 2;
   localparam int DISC_BITS   = 2 * WORD_BITS + 2;
   localparam int ROOT_BITS   = DISC_BITS / 2;
   localparam int SQ_REM_BITS = ROOT_BITS + 3;
   localparam int NUM_BITS    = WORD_BITS + 3;
   localparam int NMAG_BITS   = WORD_BITS + 2;
   localparam int DVD_BITS    = NMAG_BITS + FRAC_BITS;
   localparam int DVS_BITS    = WORD_BITS + 1;
   localparam int DREM_BITS   = DVS_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_NONE = 2'd0;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE  = 2'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_TWO  = 2'd2;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] coef_quad;
      logic signed [WORD_BITS-1:0] coef_lin;
      logic signed [WORD_BITS-1:0] coef_const;
      logic signed [WORD_BITS-1:0] target_level;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]       root_count;
      logic signed [WORD_BITS-1:0] root_plus;
      logic signed [WORD_BITS-1:0] root_minus;
      logic                        degenerate;
      logic                        overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] coef_a;
      logic signed [WORD_BITS-1:0] coef_b;
      logic                        degenerate;
      logic                        neg_disc;
      logic                        single;
   } sq_side_type;

   typedef struct packed {
      logic [DISC_BITS-1:0]   rad;
      logic [SQ_REM_BITS-1:0] rem;
      logic [ROOT_BITS-1:0]   root;
      sq_side_type            side;
   } sq_stage_type;

   typedef struct packed {
      logic [DVD_BITS-1:0]  dvd_p;
      logic [DVD_BITS-1:0]  dvd_m;
      logic [DREM_BITS-1:0] rem_p;
      logic [DREM_BITS-1:0] rem_m;
      logic [DVS_BITS-1:0]  dvs;
      logic                 neg_p;
      logic                 neg_m;
      logic                 degenerate;
      logic                 neg_disc;
      logic                 single;
   } dv_stage_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] value;
      logic                 sat;
   } sat_type;

endpackage

>>> rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the discriminant square root
// Takes two radicand bits, forms one root bit and passes the item on.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  qrs_pkg::sq_stage_type up_stage,
   output logic                  dn_valid,
   output qrs_pkg::sq_stage_type dn_stage
);

   localparam int DB = qrs_pkg::DISC_BITS;
   localparam int RB = qrs_pkg::SQ_REM_BITS;
   localparam int QB = qrs_pkg::ROOT_BITS;

   logic                  valid_ff;
   qrs_pkg::sq_stage_type stage_ff;
   qrs_pkg::sq_stage_type stage_in;
   logic [RB-1:0]         shifted;
   logic [RB-1:0]         trial;
   logic                  take;

   always_comb begin
      shifted       = {up_stage.rem[RB-3:0], up_stage.rad[DB-1 -: 2]};
      trial         = {1'b0, up_stage.root, 2'b01};
      take          = (shifted >= trial);
      stage_in.rad  = {up_stage.rad[DB-3:0], 2'b00};
      stage_in.rem  = take ? (shifted - trial) : shifted;
      stage_in.root = {up_stage.root[QB-2:0], take};
      stage_in.side = up_stage.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign dn_valid = valid_ff;
   assign dn_stage = stage_ff;

endmodule

>>> rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell: one quotient bit for both roots
// Restoring division step on the plus and minus lanes side by side.
// ----------------------------------------------------------------------------
module qrs_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  qrs_pkg::dv_stage_type up_stage,
   output logic                  dn_valid,
   output qrs_pkg::dv_stage_type dn_stage
);

   localparam int VB = qrs_pkg::DVD_BITS;
   localparam int RB = qrs_pkg::DREM_BITS;

   logic                  valid_ff;
   qrs_pkg::dv_stage_type stage_ff;
   qrs_pkg::dv_stage_type stage_in;
   logic [RB-1:0]         rp;
   logic [RB-1:0]         rm;
   logic [RB-1:0]         dext;
   logic                  take_p;
   logic                  take_m;

   always_comb begin
      dext   = {1'b0, up_stage.dvs};
      rp     = {up_stage.rem_p[RB-2:0], up_stage.dvd_p[VB-1]};
      rm     = {up_stage.rem_m[RB-2:0], up_stage.dvd_m[VB-1]};
      take_p = (rp >= dext);
      take_m = (rm >= dext);
      stage_in       = up_stage;
      stage_in.rem_p = take_p ? (rp - dext) : rp;
      stage_in.rem_m = take_m ? (rm - dext) : rm;
      // quotient bits fill in from the bottom as the dividend shifts out
      stage_in.dvd_p = {up_stage.dvd_p[VB-2:0], take_p};
      stage_in.dvd_m = {up_stage.dvd_m[VB-2:0], take_m};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign dn_valid = valid_ff;
   assign dn_stage = stage_ff;

endmodule

>>> rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*t^2 + b*t + (c - level) = 0
// Q16.16 coefficients in, root count, both roots and flags out.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start; the item is taken at that clock edge.
//   busy stays low, so a new item may be offered in every cycle.
//   Each item gives one result: rsp_valid rises with rsp_item alongside
//   once the item has passed all 88 register stages (3 front stages,
//   33 square-root cells, 1 numerator stage, 50 divider cells, 1 output
//   stage). Throughput is one item per cycle; the latency is set by the
//   bit-per-cell square root and the 50-bit quotient chain.
//   Results leave in the order items came in. The receiver cannot stall
//   and must take each result in its strobe cycle.
//   Reset clears every valid bit in the chain; items in flight are dropped
//   and no result appears until a new item is accepted.
//   A zero quadratic coefficient gives degenerate with count 0; a root
//   outside Q16.16 saturates and raises overflow.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qrs_pkg::req_type req_item,
   output logic             rsp_valid,
   output qrs_pkg::rsp_type rsp_item
);

   localparam int W   = qrs_pkg::WORD_BITS;
   localparam int F   = qrs_pkg::FRAC_BITS;
   localparam int CB  = qrs_pkg::CMAG_BITS;
   localparam int BQ  = qrs_pkg::BSQ_BITS;
   localparam int PB  = qrs_pkg::PROD_BITS;
   localparam int XB  = qrs_pkg::WIDE_BITS;
   localparam int DB  = qrs_pkg::DISC_BITS;
   localparam int QB  = qrs_pkg::ROOT_BITS;
   localparam int NB  = qrs_pkg::NUM_BITS;
   localparam int MB  = qrs_pkg::NMAG_BITS;
   localparam int VB  = qrs_pkg::DVD_BITS;
   localparam int SQ_STEPS = qrs_pkg::ROOT_BITS;
   localparam int DV_STEPS = qrs_pkg::DVD_BITS;

   // ---- stage 1: input register
   logic             s1_valid_ff;
   qrs_pkg::req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= req_item;
   end

   // ---- stage 2: magnitudes and products
   logic signed [CB-1:0] cdiff;
   logic [W-1:0]         amag1;
   logic [W-1:0]         bmag1;
   logic [CB-1:0]        cmag1;

   always_comb begin
      cdiff = {s1_req_ff.coef_const[W-1], s1_req_ff.coef_const}
            - {s1_req_ff.target_level[W-1], s1_req_ff.target_level};
      amag1 = s1_req_ff.coef_quad[W-1] ? (~s1_req_ff.coef_quad + 1'b1)
                                       : s1_req_ff.coef_quad;
      bmag1 = s1_req_ff.coef_lin[W-1] ? (~s1_req_ff.coef_lin + 1'b1)
                                      : s1_req_ff.coef_lin;
      cmag1 = cdiff[CB-1] ? (~cdiff + 1'b1) : cdiff;
   end

   logic                 s2_valid_ff;
   logic [BQ-1:0]        s2_bsq_ff;
   logic [PB-1:0]        s2_ac_ff;
   logic                 s2_add_ff;
   logic                 s2_deg_ff;
   logic signed [W-1:0]  s2_a_ff;
   logic signed [W-1:0]  s2_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_bsq_ff <= bmag1 * bmag1;
      s2_ac_ff  <= {{CB{1'b0}}, amag1} * {{W{1'b0}}, cmag1};
      // opposite signs (or zero c) make -4ac non-negative
      s2_add_ff <= (cdiff == '0) || (s1_req_ff.coef_quad[W-1] != cdiff[CB-1]);
      s2_deg_ff <= (s1_req_ff.coef_quad == '0);
      s2_a_ff   <= s1_req_ff.coef_quad;
      s2_b_ff   <= s1_req_ff.coef_lin;
   end

   // ---- stage 3: discriminant
   logic [XB-1:0] bsq_x;
   logic [XB-1:0] fourac;
   logic [XB-1:0] disc_x;
   logic          neg_disc;

   always_comb begin
      bsq_x    = {{(XB-BQ){1'b0}}, s2_bsq_ff};
      fourac   = {s2_ac_ff, 2'b00};
      neg_disc = ~s2_add_ff && (bsq_x < fourac);
      disc_x   = s2_add_ff ? (bsq_x + fourac) : (bsq_x - fourac);
   end

   logic                  sq_valid [SQ_STEPS+1];
   qrs_pkg::sq_stage_type sq_stage [SQ_STEPS+1];
   logic                  s3_valid_ff;
   qrs_pkg::sq_stage_type s3_stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_stage_ff.rad             <= disc_x[DB-1:0];
      s3_stage_ff.rem             <= '0;
      s3_stage_ff.root            <= '0;
      s3_stage_ff.side.coef_a     <= s2_a_ff;
      s3_stage_ff.side.coef_b     <= s2_b_ff;
      s3_stage_ff.side.degenerate <= s2_deg_ff;
      s3_stage_ff.side.neg_disc   <= neg_disc;
      s3_stage_ff.side.single     <= (disc_x == '0);
   end

   assign sq_valid[0] = s3_valid_ff;
   assign sq_stage[0] = s3_stage_ff;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      qrs_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (sq_valid[i]),
         .up_stage (sq_stage[i]),
         .dn_valid (sq_valid[i+1]),
         .dn_stage (sq_stage[i+1])
      );
   end

   // ---- stage 4: numerators and divisor
   qrs_pkg::sq_stage_type sq_last;
   logic signed [NB-1:0]  neg_b;
   logic signed [NB-1:0]  sroot;
   logic signed [NB-1:0]  num_p;
   logic signed [NB-1:0]  num_m;
   logic [NB-1:0]         mag_p;
   logic [NB-1:0]         mag_m;
   logic [W-1:0]          amag4;

   always_comb begin
      sq_last = sq_stage[SQ_STEPS];
      neg_b   = -{{(NB-W){sq_last.side.coef_b[W-1]}}, sq_last.side.coef_b};
      sroot   = {{(NB-QB){1'b0}}, sq_last.root};
      num_p   = neg_b + sroot;
      num_m   = neg_b - sroot;
      mag_p   = num_p[NB-1] ? (~num_p + 1'b1) : num_p;
      mag_m   = num_m[NB-1] ? (~num_m + 1'b1) : num_m;
      amag4   = sq_last.side.coef_a[W-1] ? (~sq_last.side.coef_a + 1'b1)
                                         : sq_last.side.coef_a;
   end

   logic                  dv_valid [DV_STEPS+1];
   qrs_pkg::dv_stage_type dv_stage [DV_STEPS+1];
   logic                  s4_valid_ff;
   qrs_pkg::dv_stage_type s4_stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= sq_valid[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      s4_stage_ff.dvd_p      <= {mag_p[MB-1:0], {F{1'b0}}};
      s4_stage_ff.dvd_m      <= {mag_m[MB-1:0], {F{1'b0}}};
      s4_stage_ff.rem_p      <= '0;
      s4_stage_ff.rem_m      <= '0;
      s4_stage_ff.dvs        <= {amag4, 1'b0};
      s4_stage_ff.neg_p      <= (num_p[NB-1] != sq_last.side.coef_a[W-1]);
      s4_stage_ff.neg_m      <= (num_m[NB-1] != sq_last.side.coef_a[W-1]);
      s4_stage_ff.degenerate <= sq_last.side.degenerate;
      s4_stage_ff.neg_disc   <= sq_last.side.neg_disc;
      s4_stage_ff.single     <= sq_last.side.single;
   end

   assign dv_valid[0] = s4_valid_ff;
   assign dv_stage[0] = s4_stage_ff;

   for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
      qrs_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dv_valid[j]),
         .up_stage (dv_stage[j]),
         .dn_valid (dv_valid[j+1]),
         .dn_stage (dv_stage[j+1])
      );
   end

   // ---- output stage: sign, saturation and special cases
   function automatic qrs_pkg::sat_type saturate(input logic [VB-1:0] q,
                                                 input logic neg);
      qrs_pkg::sat_type r;
      logic [VB-1:0]    lim;
      lim = VB'(1) << (W - 1);
      if (neg) begin
         r.sat   = (q > lim);
         r.value = r.sat ? {1'b1, {(W-1){1'b0}}} : (~q[W-1:0] + 1'b1);
      end else begin
         r.sat   = (q > (lim - 1'b1));
         r.value = r.sat ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
      end
      return r;
   endfunction

   qrs_pkg::dv_stage_type dv_last;
   qrs_pkg::sat_type      sat_p;
   qrs_pkg::sat_type      sat_m;
   qrs_pkg::rsp_type      rsp_in;

   always_comb begin
      dv_last = dv_stage[DV_STEPS];
      sat_p   = saturate(dv_last.dvd_p, dv_last.neg_p);
      sat_m   = saturate(dv_last.dvd_m, dv_last.neg_m);
      rsp_in  = '0;
      if (dv_last.degenerate) begin
         rsp_in.degenerate = 1'b1;
      end else if (!dv_last.neg_disc) begin
         rsp_in.root_count = dv_last.single ? qrs_pkg::COUNT_ONE : qrs_pkg::COUNT_TWO;
         rsp_in.root_plus  = sat_p.value;
         rsp_in.root_minus = sat_m.value;
         rsp_in.overflow   = sat_p.sat | sat_m.sat;
      end
   end

   logic             out_valid_ff;
   qrs_pkg::rsp_type out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid[DV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= rsp_in;
   end

   assign busy      = 1'b0;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

`ifndef ASSERT_OFF
   a_deg_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.degenerate |->
         rsp_item.root_count == qrs_pkg::COUNT_NONE && !rsp_item.overflow)
      else $error("degenerate item carries roots or overflow");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.root_count == qrs_pkg::COUNT_NONE |->
         rsp_item.root_plus == '0 && rsp_item.root_minus == '0)
      else $error("item without roots has non-zero root fields");

   a_double_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.root_count == qrs_pkg::COUNT_ONE |->
         rsp_item.root_plus == rsp_item.root_minus)
      else $error("double root differs between outputs");

   a_count_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.root_count == qrs_pkg::COUNT_NONE ||
         rsp_item.root_count == qrs_pkg::COUNT_ONE ||
         rsp_item.root_count == qrs_pkg::COUNT_TWO)
      else $error("root count out of range");

   a_chain_valid: assert property (@(posedge clock) disable iff (reset)
      sq_valid[SQ_STEPS] |=> s4_valid_ff)
      else $error("item lost between root and divider chains");
`endif

endmodule

>>> test/tb_quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver: regression for the quadratic root solver
// Directed table of coefficient sets, then random equations, each checked
// against its typed entry or an exact wide solver of a*t^2+b*t+(c-level)=0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quadratic_root_solver;

   localparam int LATENCY     = 88;
   localparam int RANDOM_ITEMS = 1700;
   localparam longint CYCLE_LIMIT = 200000;
   localparam int WB = qrs_pkg::WORD_BITS;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   qrs_pkg::req_type req_item;
   logic             rsp_valid;
   qrs_pkg::rsp_type rsp_item;

   qrs_pkg::rsp_type pending_roots[$];
   int      failures;
   int      results_seen;
   int      overflow_seen;
   int      degenerate_seen;
   int      count_seen[3];
   longint  cycles;

   quadratic_root_solver dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // root = numer / (2a) in Q16.16, truncated toward zero, saturated
   function automatic logic [WB-1:0] fixed_root(input logic signed [127:0] numer,
                                                input logic signed [127:0] a,
                                                inout logic sat);
      logic [127:0] nm;
      logic [127:0] q;
      logic         neg;
      nm  = numer < 0 ? -numer : numer;
      q   = (nm << qrs_pkg::FRAC_BITS) / ((a < 0 ? -a : a) * 2);
      neg = ((numer < 0) != (a < 0)) && (q != 0);
      if (neg) begin
         if (q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
         end
         return -q[WB-1:0];
      end
      if (q > 128'h7fff_ffff) begin
         sat = 1'b1;
         return 32'h7fff_ffff;
      end
      return q[WB-1:0];
   endfunction

   function automatic qrs_pkg::rsp_type solve_quadratic(input qrs_pkg::req_type eq);
      logic signed [127:0] a, b, c, disc, sr, trial;
      logic                sat;
      qrs_pkg::rsp_type    r;
      a = eq.coef_quad;
      b = eq.coef_lin;
      c = 128'(signed'(eq.coef_const)) - 128'(signed'(eq.target_level));
      r = '0;
      sat = 1'b0;
      if (a == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      disc = b * b - 4 * a * c;
      if (disc < 0) return r;
      sr = 0;
      for (int bit_i = 63; bit_i >= 0; bit_i--) begin
         trial = sr | (128'sd1 << bit_i);
         if (trial * trial <= disc) sr = trial;
      end
      r.root_count = disc == 0 ? qrs_pkg::COUNT_ONE : qrs_pkg::COUNT_TWO;
      r.root_plus  = fixed_root(-b + sr, a, sat);
      r.root_minus = fixed_root(-b - sr, a, sat);
      r.overflow   = sat;
      return r;
   endfunction

   // random coefficient: mostly moderate values, sometimes full range or edges
   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         2:       return 32'($signed($urandom_range(0, 8)) - 4);
         3:       return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
         default: return 32'($signed($urandom_range(0, 32'h00a0_0000)) - 32'sh0050_0000);
      endcase
   endfunction

   // leaves start high; the caller drops it when it idles or drains
   task automatic send_item(input qrs_pkg::req_type eq, input logic check_typed,
                            input qrs_pkg::rsp_type typed);
      qrs_pkg::rsp_type want;
      want = solve_quadratic(eq);
      if (check_typed && want !== typed)
         $display("%0t predictor disagrees with table: table %h predictor %h",
                  $time, typed, want);
      start    <= 1'b1;
      req_item <= eq;
      do @(posedge clock); while (busy);
      pending_roots.push_back(check_typed ? typed : want);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_roots.size() == 0) begin
            failures++;
            $display("%0t unexpected result %h", $time, rsp_item);
         end else begin
            qrs_pkg::rsp_type want;
            want = pending_roots.pop_front();
            if (rsp_item.root_count !== want.root_count ||
                rsp_item.root_plus !== want.root_plus ||
                rsp_item.root_minus !== want.root_minus ||
                rsp_item.degenerate !== want.degenerate ||
                rsp_item.overflow !== want.overflow) begin
               failures++;
               $display("%0t mismatch: expected cnt=%0d p=%h m=%h dg=%b ov=%b",
                        $time, want.root_count, want.root_plus, want.root_minus,
                        want.degenerate, want.overflow);
               $display("%0t           actual   cnt=%0d p=%h m=%h dg=%b ov=%b",
                        $time, rsp_item.root_count, rsp_item.root_plus,
                        rsp_item.root_minus, rsp_item.degenerate, rsp_item.overflow);
            end
            if (want.root_count <= qrs_pkg::COUNT_TWO) count_seen[want.root_count]++;
            if (want.overflow) overflow_seen++;
            if (want.degenerate) degenerate_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d items outstanding", pending_roots.size());
         $display("quadratic_root_solver regression: fail");
         $finish;
      end
   end

   typedef struct {
      qrs_pkg::req_type eq;
      logic             typed;
      qrs_pkg::rsp_type want;
   } table_row_type;

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;
   localparam logic [1:0]  CN = qrs_pkg::COUNT_NONE;
   localparam logic [1:0]  C1 = qrs_pkg::COUNT_ONE;
   localparam logic [1:0]  C2 = qrs_pkg::COUNT_TWO;

   table_row_type stim_table[] = '{
      // zero quadratic coefficient
      '{'{32'd0, ONE, ONE, 32'd0}, 1'b1, '{CN, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{'{32'd0, MINV, MAXV, MINV}, 1'b1, '{CN, 32'd0, 32'd0, 1'b1, 1'b0}},
      // t^2 + 1 = 0: negative discriminant
      '{'{ONE, 32'd0, ONE, 32'd0}, 1'b1, '{CN, 32'd0, 32'd0, 1'b0, 1'b0}},
      // t^2 - 1 = 0 via level
      '{'{ONE, 32'd0, 32'd0, ONE}, 1'b1,
        '{C2, ONE, 32'hffff_0000, 1'b0, 1'b0}},
      // (t-1)^2: double root
      '{'{ONE, 32'hfffe_0000, ONE, 32'd0}, 1'b1, '{C1, ONE, ONE, 1'b0, 1'b0}},
      // t^2 = 0
      '{'{ONE, 32'd0, 32'd0, 32'd0}, 1'b1, '{C1, 32'd0, 32'd0, 1'b0, 1'b0}},
      // tiny a, large b: saturating roots; then full-scale and mixed sets
      '{'{32'd1, MAXV, 32'd0, 32'd0}, 1'b0, '0},
      '{'{32'd1, MINV, 32'd0, 32'd0}, 1'b0, '0},
      '{'{32'hffff_ffff, MAXV, MAXV, MINV}, 1'b0, '0},
      '{'{MINV, MINV, MINV, MAXV}, 1'b0, '0},
      '{'{MAXV, MAXV, MAXV, MAXV}, 1'b0, '0},
      '{'{MINV, MAXV, MAXV, MINV}, 1'b0, '0},
      '{'{MAXV, MINV, MINV, MAXV}, 1'b0, '0},
      '{'{32'hffff_0000, ONE, 32'd0, 32'd0}, 1'b0, '0},
      '{'{32'h0000_8000, 32'h0003_0000, 32'hffff_8000, 32'h0000_4000}, 1'b0, '0},
      '{'{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, '0}
   };

   initial begin
      qrs_pkg::req_type eq;
      int               calm_from;
      failures = 0;
      results_seen = 0;
      overflow_seen = 0;
      degenerate_seen = 0;
      count_seen = '{0, 0, 0};
      cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) send_item(stim_table[i].eq, stim_table[i].typed,
                                        stim_table[i].want);

      // hold off until the pipe has drained
      start <= 1'b0;
      while (pending_roots.size() != 0) @(negedge clock);

      calm_from = $urandom_range(400, 1000);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < calm_from || n > calm_from + 300)
            while ($urandom_range(0, 99) < 21) begin
               start <= 1'b0;
               @(negedge clock);
            end
         eq.coef_quad    = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_coef();
         eq.coef_lin     = pick_coef();
         eq.coef_const   = pick_coef();
         eq.target_level = pick_coef();
         send_item(eq, 1'b0, '0);
         if (n == 900) begin
            start <= 1'b0;
            while (pending_roots.size() != 0) @(negedge clock);
         end
      end

      start <= 1'b0;
      while (pending_roots.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("%0d results checked: %0d none, %0d double, %0d two roots",
               results_seen, count_seen[0], count_seen[1], count_seen[2]);
      $display("%0d degenerate, %0d saturated", degenerate_seen, overflow_seen);
      if (failures == 0) begin
         $display("quadratic_root_solver regression: pass");
      end else begin
         $display("quadratic_root_solver regression: fail");
      end
      $finish;
   end

endmodule
